### src/address_ordered_free_block_table_unit_assert.svh
// Assertion macros for the free block table.
`ifndef ADDRESS_ORDERED_FREE_BLOCK_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_ORDERED_FREE_BLOCK_TABLE_UNIT_ASSERT_SVH
// Implication checked on every clock edge out of reset.
`define AOFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define AOFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/aofbt_pkg.sv
// ----------------------------------------------------------------------------
// aofbt_pkg
// Shared types and codes for the free block table.
// ----------------------------------------------------------------------------
package aofbt_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_DUP       = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic ins_shift;  // insert point takes key, cells after it take left neighbor
    logic rem_shift;  // cells at/after removed slot take right neighbor
    logic scan;       // search token moves one cell per cycle
    logic scan_start;
  } aofbt_ctl_t;
endpackage

### src/aofbt_if.sv
// ----------------------------------------------------------------------------
// aofbt_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface aofbt_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/aofbt_cell.sv
// ----------------------------------------------------------------------------
// aofbt_cell
// One table slot: holds a block, compares with the operand, shifts
// with its neighbors.
// ----------------------------------------------------------------------------
module aofbt_cell #(
  parameter int AW = 32,
  parameter int SW = 32
) (
  input  logic                  clk,
  input  aofbt_pkg::aofbt_ctl_t ctl,
  input  logic                  held,      // slot index below count
  input  logic [AW-1:0]         key_addr,
  input  logic [SW-1:0]         key_size,
  input  logic                  left_lt,   // left neighbor addr < key
  input  logic [AW-1:0]         left_addr,
  input  logic [SW-1:0]         left_size,
  input  logic [AW-1:0]         right_addr,
  input  logic [SW-1:0]         right_size,
  output logic                  lt,        // held and addr < key
  output logic                  hit,       // held, addr == key
  output logic [AW-1:0]         addr,
  output logic [SW-1:0]         size
);
  logic [AW-1:0] addr_r;
  logic [SW-1:0] size_r;
  logic          pos;   // first cell not below key

  assign addr = addr_r;
  assign size = size_r;
  assign lt   = held && (addr_r < key_addr);
  assign hit  = held && (addr_r == key_addr);
  assign pos  = !lt && left_lt;

  // on a remove every cell not below the key sits at or after the hit
  always_ff @(posedge clk) begin
    if (ctl.ins_shift && pos) begin
      addr_r <= key_addr;
      size_r <= key_size;
    end else if (ctl.ins_shift && !lt && !left_lt) begin
      addr_r <= left_addr;
      size_r <= left_size;
    end else if (ctl.rem_shift && !lt) begin
      addr_r <= right_addr;
      size_r <= right_size;
    end
  end
endmodule

### src/aofbt_chain.sv
// ----------------------------------------------------------------------------
// aofbt_chain
// Row of cells plus a search pointer that reads one cell a cycle into a
// register and compares it with the running candidate.
// ----------------------------------------------------------------------------
module aofbt_chain #(
  parameter int N  = 64,
  parameter int AW = 32,
  parameter int SW = 32,
  parameter int CW = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aofbt_pkg::aofbt_ctl_t ctl,
  input  logic [CW-1:0]         count,
  input  logic [AW-1:0]         key_addr,
  input  logic [SW-1:0]         key_size,
  output logic                  any_hit,
  output logic                  scan_done,
  output logic                  cand_valid,
  output logic [AW-1:0]         cand_addr,
  output logic [SW-1:0]         cand_size
);
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  logic [N-1:0]  lt, hit, held;
  logic [AW-1:0] a [N];
  logic [SW-1:0] s [N];
  logic [IW-1:0] idx_r;
  logic [CW-1:0] step_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign held[i] = CW'(i) < count;
    aofbt_cell #(.AW(AW), .SW(SW)) u_cell (
      .clk, .ctl, .held(held[i]),
      .key_addr, .key_size,
      .left_lt   ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .left_addr (a[(i == 0) ? 0 : i-1]),
      .left_size (s[(i == 0) ? 0 : i-1]),
      .right_addr(a[(i == N-1) ? i : i+1]),
      .right_size(s[(i == N-1) ? i : i+1]),
      .lt(lt[i]), .hit(hit[i]), .addr(a[i]), .size(s[i])
    );
  end

  assign any_hit = |hit;

  // search walk: slot under the pointer is registered, compared next cycle
  logic          first_mode;
  logic          issue;
  logic          better;
  logic          rd_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic [SW-1:0] rd_size_r;
  logic          cand_vld_r;
  logic [AW-1:0] cand_addr_r;
  logic [SW-1:0] cand_size_r;

  assign cand_valid = cand_vld_r;
  assign cand_addr  = cand_addr_r;
  assign cand_size  = cand_size_r;

  // fit mode rides on the low key bits during a search
  assign first_mode = (key_addr[1:0] != aofbt_pkg::FIT_BEST) &&
                      (key_addr[1:0] != aofbt_pkg::FIT_WORST);
  assign issue      = (step_r != count);
  assign scan_done  = ctl.scan && ((!issue && !rd_vld_r) || (cand_vld_r && first_mode));

  always_comb begin
    better = 1'b0;
    if (rd_vld_r && (rd_size_r >= key_size)) begin
      if (!cand_vld_r) better = 1'b1;
      else if (key_addr[1:0] == aofbt_pkg::FIT_BEST) better = rd_size_r < cand_size_r;
      else if (key_addr[1:0] == aofbt_pkg::FIT_WORST) better = rd_size_r > cand_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.scan_start) begin
      idx_r      <= '0;
      step_r     <= '0;
      rd_vld_r   <= 1'b0;
      cand_vld_r <= 1'b0;
    end else if (ctl.scan && !scan_done) begin
      rd_vld_r <= issue;
      if (issue) begin
        idx_r     <= idx_r + 1'b1;
        step_r    <= step_r + 1'b1;
        rd_addr_r <= a[idx_r];
        rd_size_r <= s[idx_r];
      end
      if (better) begin
        cand_vld_r  <= 1'b1;
        cand_addr_r <= rd_addr_r;
        cand_size_r <= rd_size_r;
      end
    end
  end
endmodule

### src/address_ordered_free_block_table_unit.sv
// ----------------------------------------------------------------------------
// address_ordered_free_block_table_unit
// Sorted free block table: insert, remove, first/best/worst fit search.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// in_     | in  | operation, block_addr, insert_size, request_size
// out_    | out | status, found_addr, found_size, entry_count
// cfg_    | in  | fit_mode
//
// Insert, remove, unused op: a compare/shift step, and the result beat is
// offered in the following cycle. Search: the same step, then a scan that
// reads one slot a cycle into a register and compares it in the cycle after
// (an empty table ends the scan with no slot read); first fit closes the
// scan once the first fitting slot has become the candidate. One item in flight;
// in_ready returns once the result beat is taken, a stalled beat holds.
// rst_n is synchronous; slot contents are not cleared.
module address_ordered_free_block_table_unit #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_WIDTH = 32,
  parameter int SIZE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  aofbt_if.sink      in_ch,
  aofbt_if.source    out_ch,
  aofbt_if.sink      cfg_ch
);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = 2 + ADDR_WIDTH + 2 * SIZE_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_OUT} state_t;
  state_t state_r;

  logic [1:0]            mode_r;
  logic [1:0]            op_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [SIZE_WIDTH-1:0] size_r;
  logic [SIZE_WIDTH-1:0] req_r;
  logic [CW-1:0]         count_r;
  logic [1:0]            st_r;
  logic [31:0]           fa_r, fs_r;

  aofbt_pkg::aofbt_ctl_t ctl;
  logic any_hit, scan_done, cand_valid;
  logic [ADDR_WIDTH-1:0] cand_addr, key_addr;
  logic [SIZE_WIDTH-1:0] cand_size, key_size;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = {st_r, fa_r, fs_r, 7'(count_r)};

  // search reuses key lines: fit mode on addr, request on size
  assign key_addr = (state_r == S_SCAN) ? ADDR_WIDTH'(mode_r) : addr_r;
  assign key_size = (state_r == S_SCAN) ? req_r : size_r;

  always_comb begin
    ctl = '0;
    if (state_r == S_EXEC) begin
      ctl.ins_shift  = (op_r == aofbt_pkg::OP_INSERT) && !any_hit &&
                       (count_r < CW'(MAX_BLOCKS));
      ctl.rem_shift  = (op_r == aofbt_pkg::OP_REMOVE) && any_hit;
      ctl.scan_start = 1'b1;
    end
    if (state_r == S_SCAN) ctl.scan = 1'b1;
  end

  aofbt_chain #(.N(MAX_BLOCKS), .AW(ADDR_WIDTH), .SW(SIZE_WIDTH), .CW(CW)) u_chain (
    .clk, .rst_n, .ctl, .count(count_r), .key_addr, .key_size,
    .any_hit, .scan_done, .cand_valid, .cand_addr, .cand_size
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= aofbt_pkg::FIT_FIRST;
      count_r <= '0;
    end else begin
      if (cfg_ch.valid) mode_r <= cfg_ch.data[1:0];
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          {op_r, addr_r, size_r, req_r} <= in_ch.data[IW-1:0];
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          fa_r <= '0;
          fs_r <= '0;
          state_r <= (op_r == aofbt_pkg::OP_SEARCH) ? S_SCAN : S_OUT;
          case (op_r)
            aofbt_pkg::OP_INSERT: begin
              if (any_hit) st_r <= aofbt_pkg::ST_DUP;
              else if (count_r >= CW'(MAX_BLOCKS)) st_r <= aofbt_pkg::ST_FULL;
              else begin
                st_r    <= aofbt_pkg::ST_OK;
                count_r <= count_r + 1'b1;
              end
            end
            aofbt_pkg::OP_REMOVE: begin
              if (any_hit) begin
                st_r    <= aofbt_pkg::ST_OK;
                count_r <= count_r - 1'b1;
              end else st_r <= aofbt_pkg::ST_NOT_FOUND;
            end
            aofbt_pkg::OP_SEARCH: ;  // status comes from the scan
            default: st_r <= aofbt_pkg::ST_NOT_FOUND;
          endcase
        end
        S_SCAN: if (scan_done) begin
          state_r <= S_OUT;
          st_r <= cand_valid ? aofbt_pkg::ST_OK : aofbt_pkg::ST_NOT_FOUND;
          fa_r <= cand_valid ? 32'(cand_addr) : '0;
          fs_r <= cand_valid ? 32'(cand_size) : '0;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### src/aofbt_checker.sv
// ----------------------------------------------------------------------------
// aofbt_checker
// Port-level checks for the free block table.
// ----------------------------------------------------------------------------
`include "address_ordered_free_block_table_unit_assert.svh"
module aofbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [72:0] out_data
);
  logic held_beat;  // result waiting on the receiver
  logic fail_st;    // result beat with a failing status

  assign held_beat = out_valid && !out_ready;
  assign fail_st   = out_valid && (out_data[72:71] != aofbt_pkg::ST_OK);

  `AOFB_ASSERT_IMP(a_one_item, clk, rst_n, out_valid, !in_ready, "input open with result up")
  `AOFB_ASSERT_NXT(a_hold, clk, rst_n, held_beat, out_valid && $stable(out_data), "result moved")
  `AOFB_ASSERT_IMP(a_cnt, clk, rst_n, out_valid, out_data[6:0] <= 7'd64, "count beyond table")
  `AOFB_ASSERT_IMP(a_zero, clk, rst_n, fail_st, out_data[70:7] == '0, "found fields set")
endmodule

bind address_ordered_free_block_table_unit aofbt_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data[72:0])
);
